@@ rtl/dda_line_rasterizer_defines.svh @@
// ----------------------------------------------------------------------------
// dda_line_rasterizer_defines
// Assertion macros shared by the rasterizer RTL. Expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define DDA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dda_line_rasterizer: assertion failed");

// next-cycle implication
`define DDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dda_line_rasterizer: assertion failed");

`endif

@@ rtl/dda_pkg.sv @@
// ----------------------------------------------------------------------------
// dda_pkg
// Command and status bundles between the rasterizer controller and datapath.
// ----------------------------------------------------------------------------
package dda_pkg;

  typedef struct packed {
    logic load;   // capture endpoints, differences and step count
    logic setup;  // emit start pixel, start dividers, init accumulators
    logic run;    // advance one step and emit a pixel
  } dda_cmd_t;

  typedef struct packed {
    logic zero_steps;
    logic div_done;
    logic last_step;
  } dda_sts_t;

endpackage

@@ rtl/dda_line_rasterizer.sv @@
// Sequence: once the request is taken, the start pixel is registered out of the SETUP state.
// The next pixel follows after the setup state and the increment dividers (one quotient
// bit per cycle), then one pixel per cycle.
// busy stays high from the request until the last pixel is stepped, or through the SETUP
// state only for a single-pixel segment; a new request is taken once busy drops.
// Reset: synchronous active-low rst_n returns to idle, no output; no output stall.
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: emits the pixels of a segment, start pixel first.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_defines.svh"

module dda_line_rasterizer #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [COORD_BITS-1:0] in_start_x,
  input  logic [COORD_BITS-1:0] in_start_y,
  input  logic [COORD_BITS-1:0] in_end_x,
  input  logic [COORD_BITS-1:0] in_end_y,
  output logic                  out_valid,
  output logic [COORD_BITS-1:0] out_pixel_x,
  output logic [COORD_BITS-1:0] out_pixel_y,
  output logic                  out_last
);

  dda_pkg::dda_cmd_t cmd;
  dda_pkg::dda_sts_t sts;

  dda_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .sts  (sts)
  );

  dda_datapath #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_start_x (in_start_x),
    .in_start_y (in_start_y),
    .in_end_x   (in_end_x),
    .in_end_y   (in_end_y),
    .out_valid  (out_valid),
    .out_pixel_x(out_pixel_x),
    .out_pixel_y(out_pixel_y),
    .out_last   (out_last)
  );

  `DDA_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `DDA_ASSERT_NEXT(a_last_gap, out_valid && out_last, !out_valid)

endmodule

@@ rtl/dda_div.sv @@
// ----------------------------------------------------------------------------
// dda_div
// Restoring divider, one quotient bit per cycle, numerator bits MSB first.
// ----------------------------------------------------------------------------
module dda_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 6
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [NUM_W-1:0] quo_r, quo_nxt;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;

  always_comb begin
    trial   = {rem_r, quo_r[NUM_W-1]};
    diff    = {1'b0, trial} - {2'b00, den_r};
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    if (go) begin
      cnt_nxt = CNT_W'(NUM_W);
      rem_nxt = '0;
      quo_nxt = num;
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - CNT_W'(1);
      if (!diff[DEN_W+1]) begin
        rem_nxt = diff[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (go) begin
      den_r <= den;
    end
  end

  assign done = (cnt_r == '0);
  assign quo  = quo_r;

endmodule

@@ rtl/dda_datapath.sv @@
// ----------------------------------------------------------------------------
// dda_datapath
// Endpoint capture, increment dividers, fixed-point accumulators, pixel output.
// ----------------------------------------------------------------------------
module dda_datapath #(
  parameter int COORD_BITS = 6,
  parameter int FRAC_BITS  = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dda_pkg::dda_cmd_t       cmd,
  output dda_pkg::dda_sts_t       sts,
  input  logic [COORD_BITS-1:0]   in_start_x,
  input  logic [COORD_BITS-1:0]   in_start_y,
  input  logic [COORD_BITS-1:0]   in_end_x,
  input  logic [COORD_BITS-1:0]   in_end_y,
  output logic                    out_valid,
  output logic [COORD_BITS-1:0]   out_pixel_x,
  output logic [COORD_BITS-1:0]   out_pixel_y,
  output logic                    out_last
);

  localparam int C     = COORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int NUM_W = C + F;
  localparam int AW    = C + 2 + F;

  logic [C-1:0] sx_r, sy_r, adx_r, ady_r, steps_r, left_r;
  logic         negx_r, negy_r;
  logic         negx, negy;
  logic [C-1:0] adx, ady;

  logic [NUM_W-1:0] num_x, num_y, quo_x, quo_y;
  logic             done_x, done_y, div_go;

  logic [AW-1:0] accx_r, accy_r, accx_nxt, accy_nxt, incx, incy;

  logic           out_valid_r;
  logic [C-1:0]   out_px_r, out_py_r;
  logic           out_last_r;

  // accumulators carry a half-pixel bias, so rounding is a plain truncation, clamped to the coordinate range
  function automatic logic [C-1:0] round_px(input logic [AW-1:0] a);
    logic [C+1:0] ip;
    logic [C-1:0] r;
    ip = a[AW-1:F];
    if (ip[C+1]) begin
      r = '0;
    end else if (ip[C]) begin
      r = '1;
    end else begin
      r = ip[C-1:0];
    end
    return r;
  endfunction

  always_comb begin
    negx = (in_end_x < in_start_x);
    negy = (in_end_y < in_start_y);
    adx  = negx ? (in_start_x - in_end_x) : (in_end_x - in_start_x);
    ady  = negy ? (in_start_y - in_end_y) : (in_end_y - in_start_y);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sx_r    <= in_start_x;
      sy_r    <= in_start_y;
      adx_r   <= adx;
      ady_r   <= ady;
      negx_r  <= negx;
      negy_r  <= negy;
      steps_r <= (adx > ady) ? adx : ady;
    end
  end

  // numerator = |d| * 2^F + steps/2 (round to nearest, ties away from zero)
  assign num_x  = {adx_r, F'(steps_r >> 1)};
  assign num_y  = {ady_r, F'(steps_r >> 1)};
  assign div_go = cmd.setup && (steps_r != '0);

  dda_div #(.NUM_W(NUM_W), .DEN_W(C)) u_div_x (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (num_x),
    .den  (steps_r),
    .done (done_x),
    .quo  (quo_x)
  );

  dda_div #(.NUM_W(NUM_W), .DEN_W(C)) u_div_y (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (div_go),
    .num  (num_y),
    .den  (steps_r),
    .done (done_y),
    .quo  (quo_y)
  );

  // quotient never exceeds 2^F
  assign incx     = AW'(quo_x[F:0]);
  assign incy     = AW'(quo_y[F:0]);
  assign accx_nxt = negx_r ? (accx_r - incx) : (accx_r + incx);
  assign accy_nxt = negy_r ? (accy_r - incy) : (accy_r + incy);

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      accx_r <= {2'b00, sx_r, 1'b1, (F-1)'(0)};
      accy_r <= {2'b00, sy_r, 1'b1, (F-1)'(0)};
      left_r <= steps_r;
    end else if (cmd.run) begin
      accx_r <= accx_nxt;
      accy_r <= accy_nxt;
      left_r <= left_r - C'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.setup || cmd.run;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      out_px_r   <= sx_r;
      out_py_r   <= sy_r;
      out_last_r <= (steps_r == '0);
    end else if (cmd.run) begin
      out_px_r   <= round_px(accx_nxt);
      out_py_r   <= round_px(accy_nxt);
      out_last_r <= (left_r == C'(1));
    end
  end

  assign sts.zero_steps = (steps_r == '0);
  assign sts.div_done   = done_x && done_y;
  assign sts.last_step  = (left_r == C'(1));

  assign out_valid   = out_valid_r;
  assign out_pixel_x = out_px_r;
  assign out_pixel_y = out_py_r;
  assign out_last    = out_last_r;

endmodule

@@ rtl/dda_ctrl.sv @@
// ----------------------------------------------------------------------------
// dda_ctrl
// Sequencer: capture, setup, divide, then one step per cycle; a single-pixel segment ends after setup.
// ----------------------------------------------------------------------------
`include "dda_line_rasterizer_defines.svh"

module dda_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output dda_pkg::dda_cmd_t cmd,
  input  dda_pkg::dda_sts_t sts
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_RUN   = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.zero_steps ? S_IDLE : S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_RUN;
        end
      end
      S_RUN: begin
        cmd.run = 1'b1;
        if (sts.last_step) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  `DDA_ASSERT_NEXT(a_run_ends, (state_r == S_RUN) && sts.last_step, state_r == S_IDLE)
  `DDA_ASSERT_NOW(a_div_idle_cmd, state_r == S_DIV, !cmd.run && !cmd.setup && !cmd.load)

endmodule
